// File: src/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg
// shared types and constants of the gamma-correct coverage blend core
// ----------------------------------------------------------------------------
package gcb_pkg;

    // full weight, coverage times alpha at both maximums
    localparam int FULL_WEIGHT = 255 * 255;

    localparam int FWD_DEPTH = 256;
    localparam int FWD_AW    = 8;
    localparam int TBL_W     = 11;
    localparam int WEIGHT_W  = 16;

    // input item kinds
    localparam logic [1:0] OP_PIXEL  = 2'd0;
    localparam logic [1:0] OP_FWD_WR = 2'd1;
    localparam logic [1:0] OP_INV_WR = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_COLOR_RED   = 3'd0;
    localparam logic [2:0] REG_COLOR_GREEN = 3'd1;
    localparam logic [2:0] REG_COLOR_BLUE  = 3'd2;
    localparam logic [2:0] REG_COLOR_ALPHA = 3'd3;
    localparam logic [2:0] REG_SUB_OFFSET  = 3'd4;
    localparam logic [2:0] REG_SUBPX_MODE  = 3'd5;
    localparam logic [2:0] REG_START_PHASE = 3'd6;

    // subpixel channel phases
    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;
    localparam logic [1:0] PH_NONE  = 2'd3;

    // table write request broadcast to every lane
    typedef struct packed {
        logic             fwd_we;
        logic             inv_we;
        logic [TBL_W-1:0] index;
        logic [TBL_W-1:0] value;
    } tbl_wr_t;

endpackage

// File: src/gamma_correct_coverage_blend_core.sv
// ----------------------------------------------------------------------------
// gamma_correct_coverage_blend_core
// gamma-correct blending of glyph coverage samples into destination pixels
// ----------------------------------------------------------------------------
// Each pixel sample item carries a coverage byte and the destination pixel.
// Its weight is coverage times the text alpha, interpolated toward the weight
// of the previous sample by the sub-position fraction; three channel lanes
// then map the destination through the loaded forward table, mix toward the
// text color times the oversample factor, and map back through the inverse
// table. A merge stage picks per channel between the blended and the original
// value (all three in whole-pixel mode, one in rotation in subpixel mode) and
// drives one result item per pixel sample. Each table write item loads the
// forward or the inverse table, by its op, in every lane and gives no
// result; the tables hold nothing useful until they are loaded. One item is
// in flight at a time: a pixel sample passes through the five-stage lane
// pipeline (forward read, target difference, weight multiply, reciprocal
// multiply, inverse read) into its result register, and the input opens
// again only once that sample has left the pipeline. Table writes do not
// enter the pipeline. A finished result waits in a spare register if the
// output is stalled, and the input stays closed until that register drains.
// ----------------------------------------------------------------------------
module gamma_correct_coverage_blend_core #(
    parameter int GAMMA_OVERSAMPLE = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // row_start[0], coverage[8:1], dst_red[16:9], dst_green[24:17],
    // dst_blue[32:25], table_index[43:33], table_value[54:44], zero[55]
    input  logic [55:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0] m_tdata,
    // pixel_advance
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import gcb_pkg::*;

    localparam int LAT = 5;

    // unpacked input fields
    logic        in_row_start;
    logic [7:0]  in_coverage;
    logic [7:0]  in_dst [3];
    logic [10:0] in_tidx;
    logic [10:0] in_tval;
    logic [1:0]  in_op;

    assign in_row_start = s_tdata[0];
    assign in_coverage  = s_tdata[8:1];
    assign in_dst[0]    = s_tdata[16:9];
    assign in_dst[1]    = s_tdata[24:17];
    assign in_dst[2]    = s_tdata[32:25];
    assign in_tidx      = s_tdata[43:33];
    assign in_tval      = s_tdata[54:44];
    assign in_op        = s_tuser;

    // configuration registers
    logic [7:0] color_reg [3];
    logic [7:0] color_alpha_reg;
    logic [5:0] sub_offset_reg;
    logic       subpixel_mode_reg;
    logic [1:0] start_phase_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg[0]      <= '0;
            color_reg[1]      <= '0;
            color_reg[2]      <= '0;
            color_alpha_reg   <= 8'hFF;
            sub_offset_reg    <= '0;
            subpixel_mode_reg <= 1'b0;
            start_phase_reg   <= PH_RED;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_COLOR_RED:   color_reg[0]      <= cfg_data;
                REG_COLOR_GREEN: color_reg[1]      <= cfg_data;
                REG_COLOR_BLUE:  color_reg[2]      <= cfg_data;
                REG_COLOR_ALPHA: color_alpha_reg   <= cfg_data;
                REG_SUB_OFFSET:  sub_offset_reg    <= cfg_data[5:0];
                REG_SUBPX_MODE:  subpixel_mode_reg <= cfg_data[0];
                REG_START_PHASE: start_phase_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // acceptance
    logic           in_fire;
    logic           pixel_fire;
    logic [LAT-1:0] stage_v_reg;
    logic           hold_valid_reg;

    assign s_tready   = !(|stage_v_reg) && !hold_valid_reg;
    assign in_fire    = s_tvalid && s_tready;
    assign pixel_fire = in_fire && (in_op == OP_PIXEL);

    // table writes go to every lane at once
    tbl_wr_t tbl_wr;

    assign tbl_wr.fwd_we = in_fire && (in_op == OP_FWD_WR);
    assign tbl_wr.inv_we = in_fire && (in_op == OP_INV_WR);
    assign tbl_wr.index  = in_tidx;
    assign tbl_wr.value  = in_tval;

    // channel phase and blend mask of the accepted sample
    logic [1:0] phase_reg;
    logic [1:0] phase_cur;
    logic [1:0] phase_next;
    logic [2:0] mask_cur;
    logic       adv_cur;

    always_comb begin
        phase_cur = in_row_start ? start_phase_reg : phase_reg;
        if (!subpixel_mode_reg) begin
            mask_cur   = 3'b111;
            adv_cur    = 1'b1;
            phase_next = phase_cur;
        end else begin
            unique case (phase_cur)
                PH_RED:   mask_cur = 3'b001;
                PH_GREEN: mask_cur = 3'b010;
                PH_BLUE:  mask_cur = 3'b100;
                default:  mask_cur = 3'b000;
            endcase
            adv_cur    = (phase_cur == PH_BLUE) || (phase_cur == PH_NONE);
            phase_next = adv_cur ? PH_RED : phase_cur + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_RED;
            stage_v_reg <= '0;
        end else begin
            if (pixel_fire) begin
                phase_reg <= phase_next;
            end
            stage_v_reg <= {stage_v_reg[LAT-2:0], pixel_fire};
        end
    end

    // sample context kept until its result is merged
    logic [7:0] dst_keep_reg [3];
    logic [2:0] mask_keep_reg;
    logic       adv_keep_reg;

    always_ff @(posedge aclk) begin
        if (pixel_fire) begin
            dst_keep_reg  <= in_dst;
            mask_keep_reg <= mask_cur;
            adv_keep_reg  <= adv_cur;
        end
    end

    // weight interpolation
    logic [WEIGHT_W-1:0] mix_weight;

    gcb_weight u_weight (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (pixel_fire),
        .row_start   (in_row_start),
        .coverage    (in_coverage),
        .color_alpha (color_alpha_reg),
        .sub_offset  (sub_offset_reg),
        .mix_weight  (mix_weight)
    );

    // one lane per color channel
    logic [7:0] lane_result [3];

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        gcb_lane #(
            .GAMMA_OVERSAMPLE (GAMMA_OVERSAMPLE)
        ) u_lane (
            .aclk       (aclk),
            .tbl_wr     (tbl_wr),
            .rd_dst     (in_dst[ch]),
            .color      (color_reg[ch]),
            .mix_weight (mix_weight),
            .result     (lane_result[ch])
        );
    end

    // merge: blended channels from the lanes, the rest pass through
    logic [23:0] merged;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            merged[ch*8 +: 8] = mask_keep_reg[ch] ? lane_result[ch] : dst_keep_reg[ch];
        end
    end

    // output register with a spare slot for a stalled result
    logic        res_fire;
    logic        out_free;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic [23:0] hold_data_reg;
    logic        hold_last_reg;

    assign res_fire = stage_v_reg[LAT-1];
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else if (res_fire) begin
            if (out_free) begin
                m_tvalid_reg <= 1'b1;
            end else begin
                hold_valid_reg <= 1'b1;
            end
        end else if (hold_valid_reg && out_free) begin
            m_tvalid_reg   <= 1'b1;
            hold_valid_reg <= 1'b0;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            if (out_free) begin
                m_tdata_reg <= merged;
                m_tlast_reg <= adv_keep_reg;
            end else begin
                hold_data_reg <= merged;
                hold_last_reg <= adv_keep_reg;
            end
        end else if (hold_valid_reg && out_free) begin
            m_tdata_reg <= hold_data_reg;
            m_tlast_reg <= hold_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: src/gcb_weight.sv
// ----------------------------------------------------------------------------
// gcb_weight
// sample weight and sub-position interpolation with the previous weight
// ----------------------------------------------------------------------------
module gcb_weight (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic                           row_start,
    input  logic [7:0]                     coverage,
    input  logic [7:0]                     color_alpha,
    input  logic [5:0]                     sub_offset,
    output logic [gcb_pkg::WEIGHT_W-1:0]   mix_weight
);
    import gcb_pkg::*;

    logic [WEIGHT_W-1:0] prev_weight_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [WEIGHT_W-1:0] prev_s1_reg;
    logic [WEIGHT_W-1:0] mix_reg;
    logic [WEIGHT_W-1:0] w_now;

    logic signed [16:0] wdiff;
    logic signed [23:0] scaled;
    logic signed [23:0] biased;
    logic signed [17:0] mix_sum;

    assign w_now = WEIGHT_W'(coverage) * WEIGHT_W'(color_alpha);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_weight_reg <= '0;
        end else if (load) begin
            prev_weight_reg <= w_now;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg       <= w_now;
        prev_s1_reg <= row_start ? '0 : prev_weight_reg;
        mix_reg     <= mix_sum[WEIGHT_W-1:0];
    end

    // truncation toward zero of the signed step divided by 64
    always_comb begin
        wdiff   = $signed({1'b0, prev_s1_reg}) - $signed({1'b0, w_reg});
        scaled  = 24'(wdiff) * $signed({18'd0, sub_offset});
        biased  = scaled + ((scaled < 0) ? 24'sd63 : 24'sd0);
        mix_sum = $signed({2'b00, w_reg}) + $signed(biased[23:6]);
    end

    assign mix_weight = mix_reg;

endmodule

// File: src/gcb_lane.sv
// ----------------------------------------------------------------------------
// gcb_lane
// one color channel: forward table, gamma-space mix, inverse table
// ----------------------------------------------------------------------------
module gcb_lane #(
    parameter int GAMMA_OVERSAMPLE = 8
) (
    input  logic                         aclk,
    input  gcb_pkg::tbl_wr_t             tbl_wr,
    input  logic [7:0]                   rd_dst,
    input  logic [7:0]                   color,
    input  logic [gcb_pkg::WEIGHT_W-1:0] mix_weight,
    output logic [7:0]                   result
);
    import gcb_pkg::*;

    localparam int INV_DEPTH = 256 * GAMMA_OVERSAMPLE;
    localparam int INV_AW    = $clog2(INV_DEPTH);
    localparam int TGT_W     = 8 + $clog2(GAMMA_OVERSAMPLE + 1);
    localparam int DIFF_W    = ((TGT_W > TBL_W) ? TGT_W : TBL_W) + 1;
    localparam int QW        = DIFF_W - 1;
    localparam int MAG_W     = QW + WEIGHT_W;
    localparam int RSH       = MAG_W + 16;
    localparam int RECIP_W   = MAG_W + 1;
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam int IDX_W     = DIFF_W + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RSH) + 64'(FULL_WEIGHT) - 64'd1) / 64'(FULL_WEIGHT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [TBL_W-1:0] fwd_mem [FWD_DEPTH];
    logic [7:0]       inv_mem [INV_DEPTH];

    logic [TBL_W-1:0] f1_reg, f2_reg, f3_reg, f4_reg;
    logic [QW-1:0]    tmag_reg;
    logic             neg2_reg, neg3_reg, neg4_reg;
    logic [MAG_W-1:0] pmag_reg;
    logic [QW-1:0]    q_reg;
    logic [7:0]       inv_data_reg;

    logic [TGT_W-1:0]        tgt;
    logic signed [DIFF_W-1:0] tdiff;
    logic [DIFF_W-1:0]       tabs;
    logic [PROD_W-1:0]       recip_prod;
    logic signed [IDX_W-1:0] qs;
    logic signed [IDX_W-1:0] idx_sum;
    logic [INV_AW-1:0]       inv_addr;

    // table loading and registered reads
    always_ff @(posedge aclk) begin
        if (tbl_wr.fwd_we && (32'(tbl_wr.index) < FWD_DEPTH)) begin
            fwd_mem[tbl_wr.index[FWD_AW-1:0]] <= tbl_wr.value;
        end
        if (tbl_wr.inv_we && (32'(tbl_wr.index) < INV_DEPTH)) begin
            inv_mem[INV_AW'(tbl_wr.index)] <= tbl_wr.value[7:0];
        end
        f1_reg       <= fwd_mem[rd_dst];
        inv_data_reg <= inv_mem[inv_addr];
    end

    // target minus forward value, kept as sign and magnitude
    always_comb begin
        tgt   = TGT_W'(color) * TGT_W'(GAMMA_OVERSAMPLE);
        tdiff = $signed(DIFF_W'(tgt)) - $signed(DIFF_W'(f1_reg));
        tabs  = tdiff[DIFF_W-1] ? DIFF_W'(-tdiff) : DIFF_W'(tdiff);
    end

    // quotient by the full weight through an exact reciprocal
    assign recip_prod = PROD_W'(pmag_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        tmag_reg <= tabs[QW-1:0];
        neg2_reg <= tdiff[DIFF_W-1];
        f2_reg   <= f1_reg;
        pmag_reg <= MAG_W'(tmag_reg) * MAG_W'(mix_weight);
        neg3_reg <= neg2_reg;
        f3_reg   <= f2_reg;
        q_reg    <= recip_prod[RSH +: QW];
        neg4_reg <= neg3_reg;
        f4_reg   <= f3_reg;
    end

    // clamp into the inverse table
    always_comb begin
        qs      = neg4_reg ? -$signed(IDX_W'(q_reg)) : $signed(IDX_W'(q_reg));
        idx_sum = $signed(IDX_W'(f4_reg)) + qs;
        if (idx_sum < 0) begin
            inv_addr = '0;
        end else if (idx_sum > $signed(IDX_W'(INV_DEPTH - 1))) begin
            inv_addr = INV_AW'(INV_DEPTH - 1);
        end else begin
            inv_addr = idx_sum[INV_AW-1:0];
        end
    end

    assign result = inv_data_reg;

endmodule
